FILE: src/nfcrfp_pkg.sv
`default_nettype none
package nfcrfp_pkg;

   localparam logic [7:0] CODE_ZERO  = 8'h00;
   localparam logic [7:0] CODE_FF    = 8'hFF;
   localparam logic [7:0] ID_TO_HOST = 8'hD5;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd254;
   localparam logic [7:0] MIN_LENGTH = 8'd2;

   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_LCS    = 3'd2;
   localparam logic [2:0] PH_TFI    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_DCS    = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSTART = 3'd1;
   localparam logic [2:0] ST_TRUNC   = 3'd2;
   localparam logic [2:0] ST_BADLEN  = 3'd3;
   localparam logic [2:0] ST_BADID   = 3'd4;
   localparam logic [2:0] ST_BADDCS  = 3'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buf_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_status;
      logic [2:0] status;
      logic [7:0] payload_count;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       prev_zero;
      logic [7:0] frame_length;
      logic [7:0] bytes_left;
      logic [7:0] running_sum;
      logic [7:0] sent_count;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_CLEAR = '{
      phase:        PH_SEARCH,
      prev_zero:    1'b0,
      frame_length: 8'd0,
      bytes_left:   8'd0,
      running_sum:  8'd0,
      sent_count:   8'd0
   };

endpackage
`default_nettype wire

FILE: src/nfc_response_frame_parser_top.sv
`default_nettype none
// Parses a reader-to-host normal information frame out of a captured byte
// stream: one byte word per cycle, req_word.buf_end on the buffer's last byte.
// The state update made for each byte and a single result
// register set the rate, so a new word is taken every cycle unless a result
// waits under rsp_stall. Payload bytes (after the D5 identifier) come out as
// they arrive, up to csr max_payload of them (reset 254), followed by one
// status word with last set: 0 ok, 1 no start code, 2 truncated, 3 bad length
// or length checksum, 4 wrong identifier, 5 bad data checksum. On any error
// status, discard the payload words already delivered for that frame. After a
// status, bytes are ignored up to the buffer end. Write the csr only while idle.
module nfc_response_frame_parser_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  nfcrfp_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nfcrfp_pkg::rsp_word_type rsp_word,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data
);
   import nfcrfp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   logic            step_valid;
   rsp_word_type    step_word;
   logic [7:0]      max_payload_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_word_type    rsp_word_ff;
   logic            accept;

   nfcrfp_step u_step (
      .cur_state   (state_ff),
      .req_word    (req_word),
      .max_payload (max_payload_ff),
      .nxt_state   (step_state),
      .res_valid   (step_valid),
      .res_word    (step_word)
   );

   // stall only while a result is held and not taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign state_in     = accept ? step_state : state_ff;
   assign rsp_valid_in = accept ? step_valid : (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PARSE_STATE_CLEAR;
         rsp_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_valid) begin
         rsp_word_ff <= step_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

FILE: src/nfcrfp_step.sv
`default_nettype none
module nfcrfp_step (
   input  nfcrfp_pkg::parse_state_type cur_state,
   input  nfcrfp_pkg::req_word_type    req_word,
   input  logic [7:0]                  max_payload,
   output nfcrfp_pkg::parse_state_type nxt_state,
   output logic                        res_valid,
   output nfcrfp_pkg::rsp_word_type    res_word
);
   import nfcrfp_pkg::*;

   logic [7:0] b;
   logic       buf_end;
   logic       fin_en;
   logic       fin_clear;
   logic [2:0] fin_code;
   logic [7:0] len_sum;
   logic [7:0] data_sum;
   logic [7:0] left_dec;
   logic [7:0] sent_inc;

   assign b        = req_word.rx_byte;
   assign buf_end  = req_word.buf_end;
   assign len_sum  = cur_state.frame_length + b;
   assign data_sum = cur_state.running_sum + b;
   assign left_dec = cur_state.bytes_left - 8'd1;
   assign sent_inc = cur_state.sent_count + 8'd1;

   always_comb begin
      nxt_state = cur_state;
      res_valid = 1'b0;
      res_word  = '0;
      fin_en    = 1'b0;
      fin_clear = 1'b0;
      fin_code  = ST_OK;
      case (cur_state.phase)
         PH_SEARCH: begin
            if (cur_state.prev_zero && (b == CODE_FF)) begin
               if (buf_end) begin
                  fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_TRUNC;
               end else begin
                  nxt_state.phase = PH_LEN;
               end
            end else if (buf_end) begin
               fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_NOSTART;
            end else begin
               nxt_state.prev_zero = (b == CODE_ZERO);
            end
         end
         PH_LEN: begin
            if (buf_end) begin
               fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_TRUNC;
            end else begin
               nxt_state.frame_length = b;
               nxt_state.phase        = PH_LCS;
            end
         end
         PH_LCS: begin
            if (buf_end) begin
               fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_TRUNC;
            end else if ((len_sum != 8'd0) || (cur_state.frame_length < MIN_LENGTH)) begin
               fin_en = 1'b1; fin_code = ST_BADLEN;
            end else begin
               nxt_state.phase = PH_TFI;
            end
         end
         PH_TFI: begin
            if (buf_end) begin
               fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_TRUNC;
            end else if (b != ID_TO_HOST) begin
               fin_en = 1'b1; fin_code = ST_BADID;
            end else begin
               nxt_state.running_sum = b;
               nxt_state.bytes_left  = cur_state.frame_length - 8'd1;
               nxt_state.phase = (cur_state.frame_length == 8'd1) ? PH_DCS : PH_DATA;
            end
         end
         PH_DATA: begin
            if (buf_end) begin
               fin_en = 1'b1; fin_clear = 1'b1; fin_code = ST_TRUNC;
            end else begin
               nxt_state.running_sum = data_sum;
               nxt_state.bytes_left  = left_dec;
               if (left_dec == 8'd0) begin
                  nxt_state.phase = PH_DCS;
               end
               // bytes past the cap still feed the checksum
               if (cur_state.sent_count < max_payload) begin
                  nxt_state.sent_count   = sent_inc;
                  res_valid              = 1'b1;
                  res_word.payload_byte  = b;
                  res_word.payload_count = sent_inc;
               end
            end
         end
         PH_DCS: begin
            fin_en    = 1'b1;
            fin_clear = buf_end;
            fin_code  = (data_sum != 8'd0) ? ST_BADDCS : ST_OK;
         end
         default: begin
            if (buf_end) begin
               nxt_state = PARSE_STATE_CLEAR;
            end
         end
      endcase

      if (fin_en) begin
         res_valid              = 1'b1;
         res_word.payload_byte  = 8'd0;
         res_word.is_status     = 1'b1;
         res_word.status        = fin_code;
         res_word.payload_count = cur_state.sent_count;
         res_word.last          = 1'b1;
         if (fin_clear) begin
            nxt_state = PARSE_STATE_CLEAR;
         end else begin
            nxt_state.phase = PH_DONE;
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/nfcrfp_checker.sv
`default_nettype none
module nfcrfp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input nfcrfp_pkg::rsp_word_type rsp_word
);
   import nfcrfp_pkg::*;

   // a held result word must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // input is only back-pressured by a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_payload_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.is_status |->
         rsp_word.status == ST_OK && !rsp_word.last && rsp_word.payload_count != 8'd0)
      else $error("malformed payload word");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_status |->
         rsp_word.last && rsp_word.payload_byte == 8'd0 && rsp_word.status <= ST_BADDCS)
      else $error("malformed status word");

   // no result may appear without an accepted byte the cycle before
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without an accepted byte");

endmodule

bind nfc_response_frame_parser_top nfcrfp_checker u_nfcrfp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_word    (rsp_word)
);
`default_nettype wire
